@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check prop on every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Check that cond never holds outside of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

@@ sv/rrsi_pkg.sv @@
// ----------------------------------------------------------------------------
// rrsi_pkg
// Shared types and constants of the ragged range slice index generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrsi_pkg;

  // Signed working width for positions and bounds.
  localparam int SW = 34;
  typedef logic signed [SW-1:0] sw_t;

  // Configuration register indexes.
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_SLICE_START = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SLICE_STOP  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SLICE_STEP  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_HAS_START   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_HAS_STOP    = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;

  typedef struct packed {
    logic [31:0] slice_start;
    logic [31:0] slice_stop;
    logic [31:0] slice_step;
    logic        has_start;
    logic        has_stop;
  } cfg_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic clip;
    logic check;
    logic push_idx;
    logic push_empty;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic empty;
    logic last_now;
    logic out_free;
  } sts_t;

endpackage

@@ sv/rrsi_ctrl.sv @@
// ----------------------------------------------------------------------------
// rrsi_ctrl
// Sequencer: take a request, clip the slice, check its length, emit results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrsi_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rrsi_pkg::sts_t  sts_i,
  output rrsi_pkg::cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLIP,
    S_CHECK,
    S_EMIT,
    S_EMPTY
  } state_e;

  state_e state_q, state_d;
  logic   rdy_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && rdy_q) begin
          cmd_o.load = 1'b1;
          state_d    = S_CLIP;
        end
      end
      S_CLIP: begin
        cmd_o.clip = 1'b1;
        state_d    = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.empty ? S_EMPTY : S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.push_idx = 1'b1;
          if (sts_i.last_now) begin
            state_d = S_IDLE;
          end
        end
      end
      S_EMPTY: begin
        if (sts_i.out_free) begin
          cmd_o.push_empty = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rdy_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rdy_q   <= (state_d == S_IDLE);
    end
  end

  assign in_ready_o = rdy_q;

endmodule

@@ sv/rrsi_dp.sv @@
// ----------------------------------------------------------------------------
// rrsi_dp
// Datapath: bound clipping, run length check, index stepping, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrsi_dp #(
  parameter int MAX_RUN = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rrsi_pkg::cfg_t  cfg_i,
  input  rrsi_pkg::cmd_t  cmd_i,
  output rrsi_pkg::sts_t  sts_o,
  input  logic [30:0]     list_start_i,
  input  logic [30:0]     list_stop_i,
  input  logic            last_list_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [30:0]     carry_index_o,
  output logic            has_index_o,
  output logic [31:0]     list_offset_o,
  output logic            run_last_o,
  output logic [1:0]      status_o
);

  localparam int CntW  = $clog2(MAX_RUN + 1);
  localparam int ProdW = rrsi_pkg::SW + CntW;
  localparam logic [CntW-1:0]  LastCnt = CntW'(MAX_RUN - 1);
  localparam logic [ProdW-1:0] RunMax  = ProdW'(MAX_RUN);

  function automatic rrsi_pkg::sw_t clip(rrsi_pkg::sw_t v, rrsi_pkg::sw_t lo,
                                         rrsi_pkg::sw_t hi);
    rrsi_pkg::sw_t r;
    r = v;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

  // Per-request payload.
  logic [30:0]    base_q;
  logic           last_q;
  logic [31:0]    len_q;
  rrsi_pkg::sw_t  b_q, e_q, j_q;
  logic [ProdW-1:0] prod_q;
  logic           trunc_q;
  logic [1:0]     st_q;
  logic [CntW-1:0] cnt_q;

  // Control state.
  logic [31:0]    rc_q;
  logic           out_valid_q;

  // Result register.
  logic [30:0]    oidx_q;
  logic           ohas_q;
  logic [31:0]    ooff_q;
  logic           olast_q;
  logic [1:0]     ost_q;

  rrsi_pkg::sw_t step_x, start_x, stop_x, len_x;
  rrsi_pkg::sw_t lo, hi, b_raw, e_raw, b_c, e_c, e_f;
  rrsi_pkg::sw_t span, jn;
  logic          pos, step_zero;
  logic [32:0]   step_abs;
  logic [ProdW-1:0] span_w;
  logic          last_now;
  logic [31:0]   rc_inc;

  assign step_x  = {{2{cfg_i.slice_step[31]}}, cfg_i.slice_step};
  assign start_x = {{2{cfg_i.slice_start[31]}}, cfg_i.slice_start};
  assign stop_x  = {{2{cfg_i.slice_stop[31]}}, cfg_i.slice_stop};
  assign len_x   = {2'b00, len_q};
  assign pos       = !cfg_i.slice_step[31];
  assign step_zero = (cfg_i.slice_step == 32'd0);
  assign step_abs  = pos ? {1'b0, cfg_i.slice_step}
                         : 33'(-{1'b1, cfg_i.slice_step});

  // Clip window: [0, len] forward, [-1, len-1] backward.
  always_comb begin
    lo = pos ? rrsi_pkg::sw_t'(0) : rrsi_pkg::sw_t'(-1);
    hi = pos ? len_x : len_x - rrsi_pkg::sw_t'(1);
    if (!cfg_i.has_start) begin
      b_raw = pos ? lo : hi;
    end else if (start_x < 0) begin
      b_raw = start_x + len_x;
    end else begin
      b_raw = start_x;
    end
    if (!cfg_i.has_stop) begin
      e_raw = pos ? hi : lo;
    end else if (stop_x < 0) begin
      e_raw = stop_x + len_x;
    end else begin
      e_raw = stop_x;
    end
    b_c = clip(b_raw, lo, hi);
    e_c = clip(e_raw, lo, hi);
    if (pos) begin
      e_f = (e_c < b_c) ? b_c : e_c;
    end else begin
      e_f = (e_c > b_c) ? b_c : e_c;
    end
  end

  assign span   = pos ? (e_q - b_q) : (b_q - e_q);
  assign span_w = ProdW'(unsigned'(span));
  assign jn     = j_q + step_x;
  assign last_now = trunc_q ? (cnt_q == LastCnt) : (pos ? (jn >= e_q) : (jn <= e_q));
  assign rc_inc = rc_q + 32'd1;

  assign sts_o.empty    = step_zero || (span == '0);
  assign sts_o.last_now = last_now;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_q <= list_start_i;
      last_q <= last_list_i;
      len_q  <= (list_stop_i > list_start_i) ? {1'b0, list_stop_i - list_start_i} : 32'd0;
    end
    if (cmd_i.clip) begin
      b_q    <= b_c;
      e_q    <= e_f;
      prod_q <= ProdW'(step_abs) * RunMax;
    end
    if (cmd_i.check) begin
      trunc_q <= !step_zero && (span_w > prod_q);
      st_q    <= step_zero ? rrsi_pkg::ST_ZERO
               : (span_w > prod_q) ? rrsi_pkg::ST_TRUNC : rrsi_pkg::ST_OK;
      j_q     <= b_q;
      cnt_q   <= '0;
    end
    if (cmd_i.push_idx) begin
      j_q     <= jn;
      cnt_q   <= cnt_q + CntW'(1);
      oidx_q  <= base_q + j_q[30:0];
      ohas_q  <= 1'b1;
      ooff_q  <= rc_inc;
      olast_q <= last_now;
      ost_q   <= st_q;
    end
    if (cmd_i.push_empty) begin
      oidx_q  <= '0;
      ohas_q  <= 1'b0;
      ooff_q  <= rc_q;
      olast_q <= 1'b1;
      ost_q   <= st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.push_idx) begin
        rc_q <= (last_now && last_q) ? 32'd0 : rc_inc;
      end else if (cmd_i.push_empty && last_q) begin
        rc_q <= '0;
      end
      if (cmd_i.push_idx || cmd_i.push_empty) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign carry_index_o = oidx_q;
  assign has_index_o   = ohas_q;
  assign list_offset_o = ooff_q;
  assign run_last_o    = olast_q;
  assign status_o      = ost_q;

endmodule

@@ sv/ragged_range_slice_indices_top.sv @@
// ----------------------------------------------------------------------------
// ragged_range_slice_indices_top
// Python-style slice over ragged sublists, at most one content index per result.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake             payload
//  -------  ---  --------------------  -----------------------------------------
//  s_axis   in   tvalid / tready       list_start, list_stop, last_list (tlast)
//  m_axis   out  tvalid / tready       carry_index, list_offset, has_index,
//                                      status, run_last (tlast)
//  cfg      in   cfg_we_i              slice_start/stop/step, has_start/stop
//
//  Flow: a request goes through setup (capture, bound clipping, run
//  length check) and then emission; a sublist that selects nothing gives
//  a single result. The single index stepping adder produces one index a
//  cycle while the output register is free.
//  Reset: asynchronous, active low; config registers return to their
//  defaults (step 1, everything else 0) and the running offset to zero.
//  Stalls: a held result in the output register stalls stepping; the next
//  request is taken while the final result of the previous one still waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ragged_range_slice_indices_top #(
  parameter int MAX_RUN = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input request stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [30:0] list_start, [61:31] list_stop, [63:62] 0
  input  logic        s_axis_tlast,   // last_list
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [30:0] carry_index, [62:31] list_offset, [63] 0
  output logic [2:0]  m_axis_tuser,   // [0] has_index, [2:1] status
  output logic        m_axis_tlast,   // run_last
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [rrsi_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [31:0]                   cfg_wdata_i
);

  rrsi_pkg::cfg_t cfg_q;
  rrsi_pkg::cmd_t cmd;
  rrsi_pkg::sts_t sts;

  logic [30:0] carry_index;
  logic        has_index;
  logic [31:0] list_offset;
  logic        run_last;
  logic [1:0]  status;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slice_start <= '0;
      cfg_q.slice_stop  <= '0;
      cfg_q.slice_step  <= 32'd1;
      cfg_q.has_start   <= 1'b0;
      cfg_q.has_stop    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rrsi_pkg::REG_SLICE_START: cfg_q.slice_start <= cfg_wdata_i;
        rrsi_pkg::REG_SLICE_STOP:  cfg_q.slice_stop  <= cfg_wdata_i;
        rrsi_pkg::REG_SLICE_STEP:  cfg_q.slice_step  <= cfg_wdata_i;
        rrsi_pkg::REG_HAS_START:   cfg_q.has_start   <= cfg_wdata_i[0];
        rrsi_pkg::REG_HAS_STOP:    cfg_q.has_stop    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Sequencer: one request at a time through setup and emission.
  rrsi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: clip bounds, check run length, step indices, hold the result.
  rrsi_dp #(
    .MAX_RUN (MAX_RUN)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .list_start_i  (s_axis_tdata[30:0]),
    .list_stop_i   (s_axis_tdata[61:31]),
    .last_list_i   (s_axis_tlast),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .carry_index_o (carry_index),
    .has_index_o   (has_index),
    .list_offset_o (list_offset),
    .run_last_o    (run_last),
    .status_o      (status)
  );

  // Pack the result fields, lowest field first.
  assign m_axis_tdata = {1'b0, list_offset, carry_index};
  assign m_axis_tuser = {status, has_index};
  assign m_axis_tlast = run_last;

  // A taken request blocks further requests for the setup cycles.
  `ASSERT_CLK(a_one_req, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
  // A result without an index always closes its run.
  `ASSERT_CLK(a_empty_last, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tlast)
  // A zero step never produces an index.
  `ASSERT_NEVER(a_zero_noidx, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0] && (m_axis_tuser[2:1] == rrsi_pkg::ST_ZERO))

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ragged range slice index generator: sublist
// requests go in on the input stream, and every result on the output stream
// is checked against a local slice predictor. Both streams idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int          MAX_RUN     = 64;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int          SETTLE      = 8;    // idle cycles after the last result

  // One expected result, fields as they sit on the output stream.
  typedef struct packed {
    logic [30:0] carry_index;
    logic        has_index;
    logic [31:0] list_offset;
    logic        run_last;
    logic [1:0]  status;
  } index_result_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;   // [30:0] list_start, [61:31] list_stop, [63:62] 0
  logic        s_axis_tlast  = 1'b0; // last_list
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;         // [30:0] carry_index, [62:31] list_offset, [63] 0
  logic [2:0]  m_axis_tuser;         // [0] has_index, [2:1] status
  logic        m_axis_tlast;         // run_last
  logic                          cfg_we_i    = 1'b0;
  logic [rrsi_pkg::CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [31:0]                   cfg_wdata_i = '0;

  // Local copy of the slice registers and the running offset.
  logic [31:0] cfg_start     = 32'd0;
  logic [31:0] cfg_stop      = 32'd0;
  logic [31:0] cfg_step      = 32'd1;
  logic        cfg_has_start = 1'b0;
  logic        cfg_has_stop  = 1'b0;
  logic [31:0] offset_count  = 32'd0;

  index_result_t expected_indices[$];

  int          mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int          sink_stall     = 0;
  bit          calm           = 1'b0;  // when set, neither side idles

  ragged_range_slice_indices_top #(
    .MAX_RUN (MAX_RUN)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Idle length: mostly none, often short, now and then long.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    return $urandom_range(30, 4);
  endfunction

  // Work out the indices one sublist selects under the current slice and
  // queue them up as expected results.
  function automatic void compute_slice_indices(logic [30:0] base, logic [30:0] lim,
                                                logic last);
    longint lb, ll, len, stp, b, e, n, j, i;
    logic [1:0] st;
    index_result_t r;
    lb  = base;
    ll  = lim;
    len = (ll > lb) ? ll - lb : 0;
    stp = $signed(cfg_step);
    b   = $signed(cfg_start);
    e   = $signed(cfg_stop);
    n   = 0;
    st  = rrsi_pkg::ST_OK;
    if (stp == 0) begin
      st = rrsi_pkg::ST_ZERO;
    end else if (stp > 0) begin
      // Forward: bounds clip to [0, len].
      if (!cfg_has_start) b = 0; else if (b < 0) b += len;
      if (b < 0) b = 0;
      if (b > len) b = len;
      if (!cfg_has_stop) e = len; else if (e < 0) e += len;
      if (e < 0) e = 0;
      if (e > len) e = len;
      if (e < b) e = b;
      n = (e - b + stp - 1) / stp;
    end else begin
      // Backward: bounds clip to [-1, len - 1].
      if (!cfg_has_start) b = len - 1; else if (b < 0) b += len;
      if (b < -1) b = -1;
      if (b > len - 1) b = len - 1;
      if (!cfg_has_stop) e = -1; else if (e < 0) e += len;
      if (e < -1) e = -1;
      if (e > len - 1) e = len - 1;
      if (e > b) e = b;
      n = (b - e - stp - 1) / (-stp);
    end
    if (n > MAX_RUN) begin
      n  = MAX_RUN;
      st = rrsi_pkg::ST_TRUNC;
    end
    if (n == 0) begin
      r = '{carry_index: '0, has_index: 1'b0, list_offset: offset_count,
            run_last: 1'b1, status: st};
      expected_indices.push_back(r);
    end else begin
      j = b;
      for (i = 0; i < n; i++) begin
        offset_count++;
        r = '{carry_index: 31'(lb + j), has_index: 1'b1, list_offset: offset_count,
              run_last: (i == n - 1), status: st};
        expected_indices.push_back(r);
        j += stp;
      end
    end
    if (last) offset_count = '0;
  endfunction

  // Send one sublist request; predict its results once it is taken.
  task automatic send_list(input logic [30:0] base, input logic [30:0] lim,
                           input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, lim, base};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    compute_slice_indices(base, lim, last);
  endtask

  // Drop valid, hold until every expected result is in, then let it settle.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_indices.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [rrsi_pkg::CfgIdxW-1:0] idx,
                           input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      rrsi_pkg::REG_SLICE_START: cfg_start     = data;
      rrsi_pkg::REG_SLICE_STOP:  cfg_stop      = data;
      rrsi_pkg::REG_SLICE_STEP:  cfg_step      = data;
      rrsi_pkg::REG_HAS_START:   cfg_has_start = data[0];
      rrsi_pkg::REG_HAS_STOP:    cfg_has_stop  = data[0];
      default: ;
    endcase
  endtask

  // Reprogram the whole slice, only ever with the block idle.
  task automatic set_slice(input logic [31:0] start_b, input logic [31:0] stop_b,
                           input logic [31:0] step, input logic hs, input logic hp);
    wait_drained();
    write_reg(rrsi_pkg::REG_SLICE_START, start_b);
    write_reg(rrsi_pkg::REG_SLICE_STOP, stop_b);
    write_reg(rrsi_pkg::REG_SLICE_STEP, step);
    write_reg(rrsi_pkg::REG_HAS_START, {31'd0, hs});
    write_reg(rrsi_pkg::REG_HAS_STOP, {31'd0, hp});
  endtask

  // Reset slice (step 1, no bounds): plain copy, empty and inverted lists,
  // top of the index range, truncation, and the running offset clear.
  task automatic test_default_slice();
    send_list(31'd10, 31'd15, 1'b0);
    send_list(31'd20, 31'd20, 1'b0);
    send_list(31'd40, 31'd30, 1'b0);
    send_list(31'h7FFF_FFC0, 31'h7FFF_FFFF, 1'b0);
    send_list(31'd0, 31'h7FFF_FFFF, 1'b1);
    send_list(31'h7FFF_FFFF, 31'd0, 1'b0);
    send_list(31'd5, 31'd6, 1'b1);
  endtask

  // Negative steps, with default bounds and with bounds counted from the end.
  task automatic test_reverse_slice();
    set_slice(32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_list(31'd100, 31'd105, 1'b0);
    send_list(31'd7, 31'd7, 1'b0);
    send_list(31'd0, 31'd1, 1'b1);
    set_slice(-32'sd2, -32'sd5, -32'sd2, 1'b1, 1'b1);
    send_list(31'd200, 31'd210, 1'b0);
  endtask

  // A zero step flags every request and emits no index.
  task automatic test_zero_step();
    set_slice(32'd3, 32'd9, 32'd0, 1'b1, 1'b1);
    send_list(31'd10, 31'd30, 1'b0);
    send_list(31'd0, 31'd0, 1'b1);
  endtask

  // Extreme bounds and steps of both signs.
  task automatic test_bound_extremes();
    set_slice(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1);
    send_list(31'd50, 31'd60, 1'b0);
    send_list(31'd1, 31'd2, 1'b0);
    set_slice(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1);
    send_list(31'd50, 31'd60, 1'b0);
    send_list(31'd3, 31'd3, 1'b1);
  endtask

  // Strided forward slice and a tail slice with only a start given.
  task automatic test_forward_stride();
    set_slice(32'd1, -32'sd1, 32'd3, 1'b1, 1'b1);
    send_list(31'd0, 31'd20, 1'b0);
    set_slice(-32'sd4, 32'd0, 32'd1, 1'b1, 1'b0);
    send_list(31'd300, 31'd310, 1'b0);
    send_list(31'd9, 31'd11, 1'b1);
  endtask

  function automatic logic [31:0] rand_bound();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 32'($signed($urandom_range(60)) - 30);
    if (r < 85) return $urandom();
    return (r < 92) ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  // Random slices in phases, each with a run of random sublists.
  task automatic test_random_slices();
    int          phase, k, r;
    logic [31:0] step;
    logic [30:0] base, lim, len;
    for (phase = 0; phase < 12; phase++) begin
      r = $urandom_range(99);
      if (r < 8)       step = 32'd0;
      else if (r < 60) step = 32'($signed($urandom_range(4, 1)));
      else if (r < 80) step = 32'($signed($urandom_range(40, 5)));
      else if (r < 90) step = $urandom();
      else             step = (r < 95) ? 32'h7FFF_FFFF : 32'h8000_0000;
      if (r < 60 && $urandom_range(1)) step = -step;
      set_slice(rand_bound(), rand_bound(), step, 1'($urandom_range(1)),
                1'($urandom_range(1)));
      // Some phases run with both sides flat out.
      calm = ($urandom_range(3) == 0);
      for (k = 0; k < 38; k++) begin
        r = $urandom_range(99);
        if (r < 8) begin
          base = 31'($urandom_range(32'h7FFF_FFFF, 1));
          lim  = 31'($urandom_range(base - 1));
        end else begin
          len  = (r < 14) ? 31'($urandom_range(200, 65)) : 31'($urandom_range(24));
          base = (r < 20) ? 31'h7FFF_FFFF - len
                          : 31'($urandom_range(32'h7FFF_FFFF - len));
          lim  = base + len;
        end
        send_list(base, lim, ($urandom_range(5) == 0));
        // Now and then hold the sender until the block runs dry.
        if ($urandom_range(39) == 0) wait_drained();
      end
      calm = 1'b0;
    end
  endtask

  // Sink side: ready drops for random stretches.
  always @(posedge clk_i) begin
    if (calm || sink_stall == 0) begin
      m_axis_tready <= 1'b1;
      sink_stall = pick_gap();
    end else begin
      m_axis_tready <= 1'b0;
      sink_stall--;
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    index_result_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{carry_index: m_axis_tdata[30:0], has_index: m_axis_tuser[0],
              list_offset: m_axis_tdata[62:31], run_last: m_axis_tlast,
              status: m_axis_tuser[2:1]};
      if (expected_indices.size() == 0) begin
        mismatch_count++;
        $display("%0t: expected none, actual idx=%0d has=%0b off=%0d last=%0b st=%0d",
                 $time, got.carry_index, got.has_index, got.list_offset,
                 got.run_last, got.status);
      end else begin
        want = expected_indices.pop_front();
        if (got.carry_index !== want.carry_index || got.has_index !== want.has_index ||
            got.list_offset !== want.list_offset || got.run_last !== want.run_last ||
            got.status !== want.status) begin
          mismatch_count++;
          $display({"%0t: expected idx=%0d has=%0b off=%0d last=%0b st=%0d,",
                    " actual idx=%0d has=%0b off=%0d last=%0b st=%0d"},
                   $time, want.carry_index, want.has_index, want.list_offset,
                   want.run_last, want.status, got.carry_index, got.has_index,
                   got.list_offset, got.run_last, got.status);
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_slice();
    test_reverse_slice();
    test_zero_step();
    test_bound_extremes();
    test_forward_stride();
    test_random_slices();
    // Drain everything, then allow a few idle cycles for stray results.
    wait_drained();
    if (mismatch_count == 0 && expected_indices.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
